@@ sv/aled_pkg.sv @@
// Shared types and constants for the addressable LED serializer.
// Used by the front stage, the command queue, the back end and the top level.
`default_nettype none

package aled_pkg;

    // String geometry.
    localparam int PIXEL_COUNT    = 23;
    localparam int PIX_W          = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int BITS_PER_PIXEL = 24;
    localparam int BIT_W          = $clog2(BITS_PER_PIXEL);

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request codes on the input channel.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_SEND  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 2'd3;

    // Configuration reset values.
    localparam logic [7:0] BRIGHTNESS_RST = 8'd255;
    localparam logic [7:0] BIT_PERIOD_RST = 8'd40;
    localparam logic [7:0] ONE_HIGH_RST   = 8'd18;
    localparam logic [7:0] ZERO_HIGH_RST  = 8'd7;

    // Classified operation carried through the queue.
    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_WRITE = 3'd1,
        OP_CLEAR = 3'd2,
        OP_SEND  = 3'd3,
        OP_NOP   = 3'd4
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [PIX_W-1:0] index;
        logic [23:0]      grb;
    } cmd_t;

    // Bit timing settings seen by the back end.
    typedef struct packed {
        logic [7:0] bit_period;
        logic [7:0] one_high;
        logic [7:0] zero_high;
    } timing_t;

    // One result beat.
    typedef struct packed {
        logic line_level;
        logic busy;
        logic frame_done;
    } res_t;

endpackage

`default_nettype wire

@@ sv/addressable_led_serializer_core.sv @@
// Top level of the addressable LED serializer: configuration registers,
// front stage, command queue and back end. Depends on aled_pkg and its modules.
//
// Usage: request beats arrive on in_valid/in_ready with req_type, pixel_index
// and red/green/blue. A tick advances the line waveform by one tick, a write
// stores a brightness-scaled pixel in GRB order, a clear zeroes the string and
// a send starts a frame if anything changed and no frame is running. Every
// request beat yields exactly one result beat on out_valid/out_ready carrying
// line_level, busy_res and frame_done. Configuration is written on
// cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data; the user
// must write it only while idle, and the block itself leaves this to the user.
// A result beat passes the front stage (which multiplies by brightness), one
// queue slot and the result register. Throughput is one beat per cycle while
// the receiver takes results; one tick of the waveform costs one beat.
// When the receiver stalls, the result register holds, the back end stops,
// the queue of four entries fills and in_ready then drops.
// Reset sets the configuration to its defaults, empties the store and queue,
// marks the frame as changed and leaves the line low and idle.
`default_nettype none

module addressable_led_serializer_core (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [1:0] cfg_index,
    input  wire  [7:0] cfg_data,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [1:0] req_type,
    input  wire  [4:0] pixel_index,
    input  wire  [7:0] red,
    input  wire  [7:0] green,
    input  wire  [7:0] blue,
    output logic       out_valid,
    input  wire        out_ready,
    output logic       line_level,
    output logic       busy_res,
    output logic       frame_done
);
    import aled_pkg::*;

    logic [7:0] brightness_reg, brightness_next;
    timing_t    timing_reg, timing_next;
    logic       front_valid;
    cmd_t       f_cmd, q_cmd;
    logic       f_valid, f_ready, q_valid, q_ready;
    res_t       res;

    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_comb
    begin
        brightness_next = brightness_reg;
        timing_next     = timing_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BRIGHTNESS: brightness_next        = cfg_data;
                CFG_BIT_PERIOD: timing_next.bit_period = cfg_data;
                CFG_ONE_HIGH:   timing_next.one_high   = cfg_data;
                CFG_ZERO_HIGH:  timing_next.zero_high  = cfg_data;
                default:        brightness_next        = brightness_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg       <= BRIGHTNESS_RST;
            timing_reg.bit_period <= BIT_PERIOD_RST;
            timing_reg.one_high  <= ONE_HIGH_RST;
            timing_reg.zero_high <= ZERO_HIGH_RST;
        end
        else
        begin
            brightness_reg <= brightness_next;
            timing_reg     <= timing_next;
        end
    end

    aled_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .brightness  (brightness_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .stage_valid (front_valid),
        .cmd         (f_cmd),
        .cmd_valid   (f_valid),
        .cmd_ready   (f_ready)
    );

    aled_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    aled_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .timing    (timing_reg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign line_level = res.line_level;
    assign busy_res   = res.busy;
    assign frame_done = res.frame_done;

    // The end of a frame always reports the serializer as idle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> !busy_res)
        else $error("frame_done reported while still busy");

    // An empty front stage never refuses a request beat.
    a_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !front_valid |-> in_ready)
        else $error("front stage empty but not ready");

    // A held result blocks the back end from taking a command.
    a_back_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !(q_valid && q_ready))
        else $error("command taken while result is stalled");

endmodule

`default_nettype wire

@@ sv/aled_front.sv @@
// Front stage: accepts request beats, classifies them and scales the colour.
// Depends on aled_pkg; feeds the command queue.
`default_nettype none

module aled_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire  [7:0]          brightness,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [1:0]          req_type,
    input  wire  [4:0]          pixel_index,
    input  wire  [7:0]          red,
    input  wire  [7:0]          green,
    input  wire  [7:0]          blue,
    output logic                stage_valid,
    output aled_pkg::cmd_t      cmd,
    output logic                cmd_valid,
    input  wire                 cmd_ready
);
    import aled_pkg::*;

    logic             valid_reg, valid_next;
    op_t              op_reg;
    logic [PIX_W-1:0] idx_reg;
    logic [15:0]      prod_r_reg, prod_g_reg, prod_b_reg;
    logic             load;
    op_t              op_class;

    // Exact division by 255 for a 16-bit product of two bytes.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [15:0] s;
        s = p + 16'd1 + {8'd0, p[15:8]};
        return s[15:8];
    endfunction

    // The stage takes a new beat when empty or when its beat moves on.
    assign in_ready   = !valid_reg || cmd_ready;
    assign load       = in_valid && in_ready;
    assign cmd_valid  = valid_reg;
    assign stage_valid = valid_reg;

    // Classify the request; an out-of-range write does nothing.
    always_comb
    begin
        case (req_type)
            REQ_TICK:  op_class = OP_TICK;
            REQ_WRITE: op_class = (32'(pixel_index) < PIXEL_COUNT) ? OP_WRITE : OP_NOP;
            REQ_CLEAR: op_class = OP_CLEAR;
            REQ_SEND:  op_class = OP_SEND;
            default:   op_class = OP_NOP;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (cmd_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload: the brightness products are registered before the divide.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg     <= op_class;
            idx_reg    <= PIX_W'(pixel_index);
            prod_r_reg <= 16'(red) * 16'(brightness);
            prod_g_reg <= 16'(green) * 16'(brightness);
            prod_b_reg <= 16'(blue) * 16'(brightness);
        end
    end

    // Stored word is in GRB order.
    always_comb
    begin
        cmd.op    = op_reg;
        cmd.index = idx_reg;
        cmd.grb   = {div255(prod_g_reg), div255(prod_r_reg), div255(prod_b_reg)};
    end

endmodule

`default_nettype wire

@@ sv/aled_queue.sv @@
// Short command queue between the front stage and the back end.
// Depends on aled_pkg for the command type and depth.
`default_nettype none

module aled_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  aled_pkg::cmd_t      push_cmd,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output aled_pkg::cmd_t      pop_cmd
);
    import aled_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

@@ sv/aled_back.sv @@
// Back end: holds the pixel store, runs the frame serializer and registers results.
// Depends on aled_pkg; takes commands from the queue.
`default_nettype none

module aled_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  aled_pkg::timing_t   timing,
    input  wire                 cmd_valid,
    output logic                cmd_ready,
    input  aled_pkg::cmd_t      cmd,
    output logic                out_valid,
    input  wire                 out_ready,
    output aled_pkg::res_t      res
);
    import aled_pkg::*;

    // Pixel store: data has no reset, a valid bit per entry reads as zero when clear.
    logic [23:0]            pix_data_reg [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0] pix_valid_reg;

    logic             pending_reg, pending_next;
    logic             sending_reg, sending_next;
    logic [PIX_W-1:0] pix_cnt_reg, pix_cnt_next;
    logic [BIT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0]       tick_cnt_reg, tick_cnt_next;
    logic             line_q_reg, line_q_next;
    logic             out_valid_reg, out_valid_next;
    res_t             res_reg, res_next;

    logic             fire, pix_we, pix_clr;
    logic [23:0]      word;
    logic             bit_val;
    logic [7:0]       high_cnt;
    logic             line_now;
    logic [8:0]       tick_inc;

    assign cmd_ready = !out_valid_reg || out_ready;
    assign fire      = cmd_valid && cmd_ready;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // Current bit of the frame, MSB first.
    always_comb
    begin
        word     = pix_valid_reg[pix_cnt_reg] ? pix_data_reg[pix_cnt_reg] : '0;
        bit_val  = word[BIT_W'(BITS_PER_PIXEL - 1) - bit_cnt_reg];
        high_cnt = bit_val ? timing.one_high : timing.zero_high;
        line_now = (tick_cnt_reg < high_cnt);
        tick_inc = {1'b0, tick_cnt_reg} + 9'd1;
    end

    // Command execution.
    always_comb
    begin
        pending_next   = pending_reg;
        sending_next   = sending_reg;
        pix_cnt_next   = pix_cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        tick_cnt_next  = tick_cnt_reg;
        line_q_next    = line_q_reg;
        pix_we         = 1'b0;
        pix_clr        = 1'b0;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        if (fire)
        begin
            out_valid_next      = 1'b1;
            res_next.line_level = line_q_reg;
            res_next.busy       = sending_reg;
            res_next.frame_done = 1'b0;
            case (cmd.op)
                OP_WRITE:
                begin
                    pix_we       = 1'b1;
                    pending_next = 1'b1;
                end
                OP_CLEAR:
                begin
                    pix_clr      = 1'b1;
                    pending_next = 1'b1;
                end
                OP_SEND:
                begin
                    if (!sending_reg && pending_reg)
                    begin
                        pending_next        = 1'b0;
                        sending_next        = 1'b1;
                        pix_cnt_next        = '0;
                        bit_cnt_next        = '0;
                        tick_cnt_next       = '0;
                        line_q_next         = 1'b0;
                        res_next.line_level = 1'b0;
                        res_next.busy       = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (!sending_reg)
                    begin
                        line_q_next         = 1'b0;
                        res_next.line_level = 1'b0;
                    end
                    else
                    begin
                        res_next.line_level = line_now;
                        line_q_next         = line_now;
                        tick_cnt_next       = tick_inc[7:0];
                        // End of a bit, then of a pixel, then of the frame.
                        if (tick_inc >= {1'b0, timing.bit_period})
                        begin
                            tick_cnt_next = '0;
                            bit_cnt_next  = bit_cnt_reg + 1'b1;
                            if (bit_cnt_reg == BIT_W'(BITS_PER_PIXEL - 1))
                            begin
                                bit_cnt_next = '0;
                                pix_cnt_next = pix_cnt_reg + 1'b1;
                                if (pix_cnt_reg == PIX_W'(PIXEL_COUNT - 1))
                                begin
                                    pix_cnt_next        = '0;
                                    sending_next        = 1'b0;
                                    line_q_next         = 1'b0;
                                    res_next.frame_done = 1'b1;
                                end
                            end
                        end
                        res_next.busy = sending_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b1;
            sending_reg   <= 1'b0;
            pix_cnt_reg   <= '0;
            bit_cnt_reg   <= '0;
            tick_cnt_reg  <= '0;
            line_q_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            pix_valid_reg <= '0;
        end
        else
        begin
            pending_reg   <= pending_next;
            sending_reg   <= sending_next;
            pix_cnt_reg   <= pix_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            tick_cnt_reg  <= tick_cnt_next;
            line_q_reg    <= line_q_next;
            out_valid_reg <= out_valid_next;
            if (pix_clr)
                pix_valid_reg <= '0;
            else if (pix_we)
                pix_valid_reg[cmd.index] <= 1'b1;
        end
    end

    // Result payload and pixel data.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (pix_we)
            pix_data_reg[cmd.index] <= cmd.grb;
    end

endmodule

`default_nettype wire
